// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, masked while reset is asserted
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// concurrent check on clk, also active during reset
`define ASSERT_CLK_NORST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== hw/rtl/tfwa_pkg.sv =====
// shared constants for the temperature frame window average block
package tfwa_pkg;

  localparam int BYTE_W               = 8;
  localparam int READING_W            = 15;
  localparam int AVG_W                = 15;
  localparam int COUNT_OUT_W          = 6;
  localparam int IN_TDATA_W           = 8;
  localparam int OUT_FIELDS_W         = 3 * BYTE_W + READING_W + AVG_W + COUNT_OUT_W;
  localparam int OUT_TDATA_W          = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W            = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int DEFAULT_WINDOW_DEPTH = 32;
  localparam int FRAC_SCALE           = 100;
  localparam int READING_MAX          = 25755;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h53;

endpackage

// ===== hw/rtl/tfwa_ram.sv =====
// generic single-port-write ram with registered read
module tfwa_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/tfwa_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module tfwa_div #(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 6,
  parameter int QUOT_W     = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] dq_r;
  logic [DIVIDEND_W-1:0] dq_nxt;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  always_comb begin
    trial   = {rem_r, dq_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    dq_nxt  = {dq_r[DIVIDEND_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      dq_r   <= '0;
      dvs_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
        rem_r  <= '0;
        dq_r   <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        dq_r  <= dq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dq_r[QUOT_W-1:0];

endmodule

// ===== hw/rtl/temperature_frame_window_average.sv =====
// top level: frame parser, reading ring, running sum and serial average
// a frame's last byte gives its result through one ring read, one bit per cycle through the
// divider, and one output load
// throughput: other bytes are taken one per cycle; a frame's last byte holds off the next byte
// until the average of that frame is in the output register
// reset: synchronous active-low rst_n clears frame state, sum, slot and output valid
module temperature_frame_window_average #(
  parameter int WINDOW_DEPTH = tfwa_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tfwa_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] link_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] hour, [15:8] minute, [23:16] second, [38:24] reading_hundredths,
  // [53:39] average_hundredths, [59:54] window_count, [63:60] zero
  output logic [tfwa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = tfwa_pkg::READING_W + SLOT_W;
  localparam int RW     = tfwa_pkg::READING_W;
  localparam int BW     = tfwa_pkg::BYTE_W;

  typedef enum logic [2:0] {
    PH_WAIT, PH_HOUR, PH_MINUTE, PH_SECOND, PH_WHOLE, PH_FRAC
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_READ, ST_DIV, ST_HOLD
  } ctl_t;

  phase_t                          phase_r, phase_nxt;
  ctl_t                            state_r, state_nxt;
  logic [BW-1:0]                   hour_r, hour_nxt;
  logic [BW-1:0]                   minute_r, minute_nxt;
  logic [BW-1:0]                   second_r, second_nxt;
  logic [BW-1:0]                   whole_r, whole_nxt;
  logic [RW-1:0]                   reading_r, reading_nxt;
  logic [SLOT_W-1:0]               slot_r, slot_nxt;
  logic                            filled_r, filled_nxt;
  logic [SUM_W-1:0]                sum_r, sum_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [tfwa_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                            in_fire;
  logic [BW-1:0]                   link_byte;
  logic                            ram_re;
  logic                            ram_we;
  logic [RW-1:0]                   ram_rdata;
  logic [SUM_W-1:0]                old_entry;
  logic                            div_start;
  logic                            div_done;
  logic [tfwa_pkg::AVG_W-1:0]      div_quot;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign link_byte = in_tdata[BW-1:0];
  assign old_entry = filled_r ? SUM_W'(ram_rdata) : '0;

  always_comb begin
    phase_nxt     = phase_r;
    state_nxt     = state_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    whole_nxt     = whole_r;
    reading_nxt   = reading_r;
    slot_nxt      = slot_r;
    filled_nxt    = filled_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (phase_r)
            PH_WAIT: begin
              if (link_byte == tfwa_pkg::START_BYTE) begin
                phase_nxt = PH_HOUR;
              end
            end
            PH_HOUR: begin
              hour_nxt  = link_byte;
              phase_nxt = PH_MINUTE;
            end
            PH_MINUTE: begin
              minute_nxt = link_byte;
              phase_nxt  = PH_SECOND;
            end
            PH_SECOND: begin
              second_nxt = link_byte;
              phase_nxt  = PH_WHOLE;
            end
            PH_WHOLE: begin
              whole_nxt = link_byte;
              phase_nxt = PH_FRAC;
            end
            PH_FRAC: begin
              reading_nxt = RW'(whole_r) * RW'(tfwa_pkg::FRAC_SCALE) + RW'(link_byte);
              phase_nxt   = PH_WAIT;
              ram_re      = 1'b1;
              state_nxt   = ST_READ;
            end
            default: phase_nxt = PH_WAIT;
          endcase
        end
      end
      ST_READ: begin
        // replace the oldest entry once the ring has wrapped
        sum_nxt   = sum_r - old_entry + SUM_W'(reading_r);
        ram_we    = 1'b1;
        count_nxt = filled_r ? CNT_W'(WINDOW_DEPTH) : CNT_W'(slot_r) + CNT_W'(1);
        if (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) begin
          slot_nxt   = '0;
          filled_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {tfwa_pkg::OUT_PAD_W'(0),
                           tfwa_pkg::COUNT_OUT_W'(count_r),
                           div_quot,
                           reading_r,
                           second_r,
                           minute_r,
                           hour_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      state_r     <= ST_IDLE;
      hour_r      <= '0;
      minute_r    <= '0;
      second_r    <= '0;
      whole_r     <= '0;
      reading_r   <= '0;
      slot_r      <= '0;
      filled_r    <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      phase_r     <= phase_nxt;
      state_r     <= state_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      second_r    <= second_nxt;
      whole_r     <= whole_nxt;
      reading_r   <= reading_nxt;
      slot_r      <= slot_nxt;
      filled_r    <= filled_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  tfwa_ram #(
    .WIDTH (RW),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (reading_r),
    .re    (ram_re),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  tfwa_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W),
    .QUOT_W     (tfwa_pkg::AVG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (count_nxt),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/tfwa_chk.sv =====
// port-level checker for the temperature frame window average block
`include "assert_macros.svh"

module tfwa_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tfwa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic [tfwa_pkg::READING_W-1:0] reading_f;
  logic [tfwa_pkg::AVG_W-1:0]     average_f;
  logic                           value_ok;

  assign reading_f = out_tdata[38:24];
  assign average_f = out_tdata[53:39];
  assign value_ok  = (reading_f <= tfwa_pkg::READING_W'(tfwa_pkg::READING_MAX)) &&
                     (average_f <= tfwa_pkg::AVG_W'(tfwa_pkg::READING_MAX));

  // a stalled result word holds
  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  // a result never appears in the cycle right after an input word
  `ASSERT_CLK(a_no_fast_result, in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
  // reading and average stay within the range of a frame
  `ASSERT_CLK(a_value_range, out_tvalid |-> value_ok)
  // reset empties the output register
  `ASSERT_CLK_NORST(a_reset_clears, !rst_n |=> !out_tvalid)

endmodule

bind temperature_frame_window_average tfwa_chk u_tfwa_chk (.*);

// ===== bench/tb.sv =====
// testbench for the temperature frame window average block
`timescale 1ns / 100ps

module tb;

  localparam int RING_DEPTH = tfwa_pkg::DEFAULT_WINDOW_DEPTH;
  localparam int FRAME_BYTE_TARGET = 1700;
  localparam int CALM_AFTER = 1450;
  localparam int DRAIN_CYCLES = 60;

  typedef enum logic [2:0] {
    WAIT_START,
    GET_HOUR,
    GET_MINUTE,
    GET_SECOND,
    GET_WHOLE,
    GET_HUNDREDTHS
  } link_phase_t;

  // packed from the lowest bit up: hour, minute, second, reading, average, count
  typedef struct packed {
    logic [tfwa_pkg::COUNT_OUT_W-1:0] count;
    logic [tfwa_pkg::AVG_W-1:0]       average;
    logic [tfwa_pkg::READING_W-1:0]   reading;
    logic [tfwa_pkg::BYTE_W-1:0]      second;
    logic [tfwa_pkg::BYTE_W-1:0]      minute;
    logic [tfwa_pkg::BYTE_W-1:0]      hour;
  } frame_result_t;

  typedef struct {
    logic [tfwa_pkg::BYTE_W-1:0] link_byte;
    bit                          typed;
    frame_result_t               want;
  } directed_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [tfwa_pkg::IN_TDATA_W-1:0]  in_tdata;   // [7:0] link_byte
  logic                             out_tvalid;
  logic                             out_tready;
  // [7:0] hour, [15:8] minute, [23:16] second, [38:24] reading_hundredths,
  // [53:39] average_hundredths, [59:54] window_count, [63:60] zero
  logic [tfwa_pkg::OUT_TDATA_W-1:0] out_tdata;

  // model of the frame parser and reading ring
  link_phase_t                    link_phase;
  logic [tfwa_pkg::BYTE_W-1:0]    hour_q;
  logic [tfwa_pkg::BYTE_W-1:0]    minute_q;
  logic [tfwa_pkg::BYTE_W-1:0]    second_q;
  logic [tfwa_pkg::BYTE_W-1:0]    whole_q;
  logic [tfwa_pkg::READING_W-1:0] reading_ring [RING_DEPTH];
  int unsigned                    ring_slot;
  bit                             ring_full;
  int unsigned                    ring_sum;

  frame_result_t pending_results [$];
  int            mismatches;
  bit            calm;
  int            stall_left = 0;

  directed_row_t directed_rows [27] = '{
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{tfwa_pkg::START_BYTE, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{tfwa_pkg::START_BYTE, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, '{hour: 8'hFF, minute: 8'h00, second: 8'h53,
                     reading: 15'd25755, average: 15'd25755, count: 6'd1}},
    '{tfwa_pkg::START_BYTE, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{hour: 8'h00, minute: 8'h00, second: 8'h00,
                     reading: 15'd0, average: 15'd12877, count: 6'd2}},
    '{tfwa_pkg::START_BYTE, 1'b0, '0},
    '{8'd23, 1'b0, '0},
    '{8'd59, 1'b0, '0},
    '{8'd59, 1'b0, '0},
    '{8'd20, 1'b0, '0},
    '{8'd99, 1'b1, '{hour: 8'd23, minute: 8'd59, second: 8'd59,
                     reading: 15'd2099, average: 15'd9284, count: 6'd3}},
    '{8'h52, 1'b0, '0},
    '{tfwa_pkg::START_BYTE, 1'b0, '0},
    '{tfwa_pkg::START_BYTE, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'd100, 1'b0, '0}
  };

  temperature_frame_window_average dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic parse_link_byte(input logic [tfwa_pkg::BYTE_W-1:0] b, output bit done,
                                 output frame_result_t res);
    int unsigned                    count;
    logic [tfwa_pkg::READING_W-1:0] reading;
    done = 1'b0;
    res = '0;
    case (link_phase)
      WAIT_START: begin
        if (b == tfwa_pkg::START_BYTE) link_phase = GET_HOUR;
      end
      GET_HOUR: begin
        hour_q = b;
        link_phase = GET_MINUTE;
      end
      GET_MINUTE: begin
        minute_q = b;
        link_phase = GET_SECOND;
      end
      GET_SECOND: begin
        second_q = b;
        link_phase = GET_WHOLE;
      end
      GET_WHOLE: begin
        whole_q = b;
        link_phase = GET_HUNDREDTHS;
      end
      default: begin
        link_phase = WAIT_START;
        reading = tfwa_pkg::READING_W'(whole_q * tfwa_pkg::FRAC_SCALE + b);
        if (ring_full) ring_sum = ring_sum - reading_ring[ring_slot];
        reading_ring[ring_slot] = reading;
        ring_sum = ring_sum + reading;
        if (ring_slot == RING_DEPTH - 1) begin
          ring_slot = 0;
          ring_full = 1'b1;
        end else begin
          ring_slot = ring_slot + 1;
        end
        count = ring_full ? RING_DEPTH : ring_slot;
        res.hour = hour_q;
        res.minute = minute_q;
        res.second = second_q;
        res.reading = reading;
        res.average = tfwa_pkg::AVG_W'(ring_sum / count);
        res.count = tfwa_pkg::COUNT_OUT_W'(count);
        done = 1'b1;
      end
    endcase
  endtask

  task automatic send_link_byte(input logic [tfwa_pkg::BYTE_W-1:0] b, input bit typed,
                                input frame_result_t want);
    bit            done;
    frame_result_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    parse_link_byte(b, done, res);
    if (done) pending_results.push_back(typed ? want : res);
  endtask

  task automatic send_random_byte();
    send_link_byte(tfwa_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_frame_result(input frame_result_t got);
    frame_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with no frame pending: %h", got);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    compare_field("hour", want.hour, got.hour);
    compare_field("minute", want.minute, got.minute);
    compare_field("second", want.second, got.second);
    compare_field("reading_hundredths", want.reading, got.reading);
    compare_field("average_hundredths", want.average, got.average);
    compare_field("window_count", want.count, got.count);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_frame_result(frame_result_t'(out_tdata[$bits(frame_result_t)-1:0]));
    end
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    out_tready <= (stall_left == 0);
  end

  initial begin
    int          pick;
    int          extra;
    int unsigned frame_bytes;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    calm = 1'b0;
    mismatches = 0;
    frame_bytes = 0;
    link_phase = WAIT_START;
    hour_q = '0;
    minute_q = '0;
    second_q = '0;
    whole_q = '0;
    ring_slot = 0;
    ring_full = 1'b0;
    ring_sum = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_link_byte(directed_rows[i].link_byte, directed_rows[i].typed,
                     directed_rows[i].want);
    end

    while (frame_bytes < FRAME_BYTE_TARGET) begin
      calm = (frame_bytes >= CALM_AFTER);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // complete frame, hundredths mostly in range
        send_link_byte(tfwa_pkg::START_BYTE, 1'b0, '0);
        repeat (4) send_random_byte();
        if ($urandom_range(0, 1) == 0) begin
          send_link_byte(tfwa_pkg::BYTE_W'($urandom_range(0, 99)), 1'b0, '0);
        end else begin
          send_random_byte();
        end
        frame_bytes += 6;
      end else if (pick < 90) begin
        // line noise between frames
        extra = $urandom_range(1, 4);
        repeat (extra) send_random_byte();
        frame_bytes += extra;
      end else begin
        // cut-off frame, the next start byte lands inside it
        extra = $urandom_range(1, 4);
        send_link_byte(tfwa_pkg::START_BYTE, 1'b0, '0);
        repeat (extra) send_random_byte();
        frame_bytes += extra + 1;
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
